// ===== hdl/rgbrle_pkg.sv =====
`default_nettype none

package rgbrle_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic [BYTE_W-1:0] third_byte;
        logic              last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [LEN_W-1:0]  run_length;
        logic [BYTE_W-1:0] run_first_byte;
        logic [BYTE_W-1:0] run_second_byte;
        logic [BYTE_W-1:0] run_third_byte;
        logic              frame_end;
    } record_t;

    // one queue entry per request that closes a run and/or ends the frame
    typedef struct packed {
        logic    has_close;
        record_t close_rec;
        logic    has_final;
        record_t final_rec;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

`default_nettype wire

// ===== hdl/rgbrle_front.sv =====
`default_nettype none

module rgbrle_front
    import rgbrle_pkg::*;
#(
    parameter int unsigned MAX_RUN = 255
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire pixel_t pixel,
    input  wire logic   accept,
    output logic        push,
    output cmd_t        cmd
);

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_RUN);

    logic [BYTE_W-1:0] first_reg,  first_next;
    logic [BYTE_W-1:0] second_reg, second_next;
    logic [BYTE_W-1:0] third_reg,  third_next;
    logic [LEN_W-1:0]  count_reg,  count_next;
    logic              active_reg, active_next;

    logic same;
    logic extend;
    logic close;

    assign same   = (pixel.first_byte == first_reg) && (pixel.second_byte == second_reg)
                 && (pixel.third_byte == third_reg);
    assign extend = active_reg && same && (count_reg < MaxLen);
    assign close  = active_reg && !extend;

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        count_next  = count_reg;
        active_next = active_reg;
        if (accept)
        begin
            if (extend)
            begin
                count_next = count_reg + LEN_W'(1);
            end
            else
            begin
                first_next  = pixel.first_byte;
                second_next = pixel.second_byte;
                third_next  = pixel.third_byte;
                count_next  = LEN_W'(1);
                active_next = 1'b1;
            end
            if (pixel.last_pixel)
            begin
                count_next  = '0;
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        push = accept && (close || pixel.last_pixel);

        cmd.has_close                 = close;
        cmd.close_rec.run_length      = count_reg;
        cmd.close_rec.run_first_byte  = first_reg;
        cmd.close_rec.run_second_byte = second_reg;
        cmd.close_rec.run_third_byte  = third_reg;
        cmd.close_rec.frame_end       = 1'b0;

        cmd.has_final                 = pixel.last_pixel;
        cmd.final_rec.run_length      = extend ? (count_reg + LEN_W'(1)) : LEN_W'(1);
        cmd.final_rec.run_first_byte  = extend ? first_reg  : pixel.first_byte;
        cmd.final_rec.run_second_byte = extend ? second_reg : pixel.second_byte;
        cmd.final_rec.run_third_byte  = extend ? third_reg  : pixel.third_byte;
        cmd.final_rec.frame_end       = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
            third_reg  <= '0;
            count_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            count_reg  <= count_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rgbrle_queue.sv =====
`default_nettype none

module rgbrle_queue
    import rgbrle_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output qstat_t    stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == FullCnt);
    assign stat.empty = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rgbrle_back.sv =====
`default_nettype none

module rgbrle_back
    import rgbrle_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t head,
    input  wire logic head_valid,
    output logic      pop,
    output record_t   record,
    output logic      record_valid,
    input  wire logic record_ready
);

    record_t out_reg,   out_next;
    logic    valid_reg, valid_next;
    logic    phase_reg, phase_next;   // close record of head entry already sent

    logic load;
    logic send_close;

    assign load       = !valid_reg || record_ready;
    assign send_close = head.has_close && !phase_reg;

    always_comb
    begin
        out_next   = out_reg;
        valid_next = valid_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                out_next = send_close ? head.close_rec : head.final_rec;
                if (send_close && head.has_final)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    assign record       = out_reg;
    assign record_valid = valid_reg;

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rgb_run_length_encoder.sv =====
// RGB run-length encoder.
// Pixel channel (pixel, pixel_valid, pixel_ready): one 24-bit pixel per request,
// last_pixel marks the end of a frame. Record channel (record, record_valid,
// record_ready): run length 1..MAX_RUN, the run pixel bytes, frame_end on the
// last record of a frame.
// A pixel that matches the open run and finds it below MAX_RUN gives nothing;
// a different pixel or a full run closes the run into one record. A last pixel
// adds the final record, so one pixel can give two records.
// Throughput: one pixel per cycle while pixel_ready is high; the record port moves
// one record per cycle while record_ready is high, so a pixel that gives two records
// occupies the record port for both in turn. Path: a record passes from the command
// queue into the output register; a second record from the same pixel follows it.
// When the receiver stalls, commands collect in the QUEUE_DEPTH-entry queue;
// pixel_ready drops only when the queue is full.
// Reset: no run is open, queue and output register are empty, pixel_ready is
// high right after reset.
`default_nettype none

module rgb_run_length_encoder
    import rgbrle_pkg::*;
#(
    parameter int unsigned MAX_RUN     = 255,
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire pixel_t pixel,
    input  wire logic   pixel_valid,
    output logic        pixel_ready,
    output record_t     record,
    output logic        record_valid,
    input  wire logic   record_ready
);

    logic   accept;
    logic   push;
    cmd_t   push_cmd;
    logic   pop;
    cmd_t   head;
    qstat_t stat;

    assign pixel_ready = !stat.full;
    assign accept      = pixel_valid && pixel_ready;

    rgbrle_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel),
        .accept (accept),
        .push   (push),
        .cmd    (push_cmd)
    );

    rgbrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    rgbrle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (!stat.empty),
        .pop          (pop),
        .record       (record),
        .record_valid (record_valid),
        .record_ready (record_ready)
    );

endmodule

`default_nettype wire

// ===== hdl/rgbrle_checker.sv =====
`default_nettype none

module rgbrle_checker
    import rgbrle_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    pixel_ready,
    input wire record_t record,
    input wire logic    record_valid,
    input wire logic    record_ready
);

    // stalled record holds
    a_record_hold: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && !record_ready |=> record_valid && $stable(record))
        else $error("record changed while stalled");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid |-> record.run_length != '0)
        else $error("zero-length run");

    // backpressure only when output side is stalled with work pending
    a_ready_low_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> record_valid)
        else $error("pixel_ready low with no record pending");

    // idle right after reset
    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> pixel_ready && !record_valid)
        else $error("not idle after reset");

endmodule

bind rgb_run_length_encoder rgbrle_checker u_rgbrle_checker (.*);

`default_nettype wire
